// ----- hw/rtl/cdpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cdpc_pkg
// Shared types and constants for the crop, decimate and pixel converter.
// ----------------------------------------------------------------------------
package cdpc_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int COORD_W    = 12;
	localparam int LIM_W      = 13;
	localparam int CROP_W     = 12;
	localparam int STEP_W     = 8;
	localparam int FMT_W      = 3;
	localparam int CMP_W      = ((DIM_W > LIM_W) ? DIM_W : LIM_W) + 1;
	localparam int COLOUR_W   = 8;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int NUM_LANES  = 2;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int PROD_W     = 20;

	// pixel formats
	localparam logic [FMT_W-1:0] FMT_UYVY    = 3'd0;
	localparam logic [FMT_W-1:0] FMT_YUYV    = 3'd1;
	localparam logic [FMT_W-1:0] FMT_BGR16   = 3'd2;
	localparam logic [FMT_W-1:0] FMT_BGR24   = 3'd3;
	localparam logic [FMT_W-1:0] FMT_RGB32   = 3'd4;
	localparam logic [FMT_W-1:0] FMT_BGR32   = 3'd5;
	localparam logic [FMT_W-1:0] FMT_INVALID = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_H_STEP       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_V_STEP       = 3'd7;

	typedef struct packed {
		logic [FMT_W-1:0]  pixel_format;
		logic [LIM_W-1:0]  line_width;
		logic [CROP_W-1:0] crop_left;
		logic [LIM_W-1:0]  col_limit;
		logic [CROP_W-1:0] crop_top;
		logic [LIM_W-1:0]  row_limit;
		logic [STEP_W-1:0] h_step;
		logic [STEP_W-1:0] v_step;
	} cfg_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] blue;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] red;
	} rgb_t;

	// red sits in the lowest bits, as on the output bus
	typedef struct packed {
		logic [COORD_W-1:0]  out_y;
		logic [COORD_W-1:0]  out_x;
		logic [COLOUR_W-1:0] blue;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] red;
	} res_t;

	// kept flags and destination coordinates of the pixels of one word
	typedef struct packed {
		logic [NUM_LANES-1:0]              kept;
		logic [NUM_LANES-1:0][COORD_W-1:0] x;
		logic [NUM_LANES-1:0][COORD_W-1:0] y;
	} pos_t;

	typedef struct packed {
		logic [NUM_LANES-1:0] kept;
		res_t [NUM_LANES-1:0] res;
	} pair_t;

endpackage

// ----- hw/rtl/crop_decimate_pixel_converter.sv -----
// ----------------------------------------------------------------------------
// crop_decimate_pixel_converter
// Crops and decimates a raster pixel stream and converts kept pixels to RGB888.
// ----------------------------------------------------------------------------
// One 32-bit source word is taken per clock unless the input is held off.
// UYVY, YUYV and BGR16 words carry two pixels that are handled by two
// conversion lanes side by side; the other formats use lane 0 only. Each kept
// pixel leaves as one output transaction with its destination column and row,
// so a word whose two pixels are both kept takes two output transactions and
// the sustained rate is then set by the output port at one pixel per clock
// while it is ready. A result passes three pipeline stages and a queue write
// before it can leave. The input is held off when the eight-entry result queue
// plus the three stages in flight could not take another word. Configuration
// is taken every cycle and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module crop_decimate_pixel_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cdpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// source words
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [cdpc_pkg::WORD_W-1:0]         s_axis_tdata,  // source_word
	input  logic                                s_axis_tuser,  // start_of_frame
	// kept pixels
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [$bits(cdpc_pkg::res_t)-1:0]   m_axis_tdata,  // red, green, blue, out_x, out_y
	output logic                                m_axis_tlast   // last_of_run
);
	import cdpc_pkg::*;

	cfg_t                  cfg_q;
	pos_t                  pos;
	pos_t                  pos_s1, pos_s2, pos_s3;
	logic                  vld_s1, vld_s2, vld_s3;
	logic                  accept;
	rgb_t                  lane_rgb [NUM_LANES];
	pair_t                 entry;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [FIFO_CNT_W:0]   claimed;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= FMT_UYVY;
			cfg_q.line_width   <= LIM_W'(640);
			cfg_q.crop_left    <= '0;
			cfg_q.col_limit    <= LIM_W'(640);
			cfg_q.crop_top     <= '0;
			cfg_q.row_limit    <= LIM_W'(480);
			cfg_q.h_step       <= STEP_W'(1);
			cfg_q.v_step       <= STEP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[FMT_W-1:0];
				REG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data[LIM_W-1:0];
				REG_CROP_LEFT:    cfg_q.crop_left    <= cfg_data[CROP_W-1:0];
				REG_COL_LIMIT:    cfg_q.col_limit    <= cfg_data[LIM_W-1:0];
				REG_CROP_TOP:     cfg_q.crop_top     <= cfg_data[CROP_W-1:0];
				REG_ROW_LIMIT:    cfg_q.row_limit    <= cfg_data[LIM_W-1:0];
				REG_H_STEP:       cfg_q.h_step       <= cfg_data[STEP_W-1:0];
				REG_V_STEP:       cfg_q.v_step       <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// queue slots already promised to words still in the pipeline
	assign claimed       = (FIFO_CNT_W+1)'(fifo_cnt) + (FIFO_CNT_W+1)'(vld_s1)
		+ (FIFO_CNT_W+1)'(vld_s2) + (FIFO_CNT_W+1)'(vld_s3);
	assign s_axis_tready = claimed < (FIFO_CNT_W+1)'(FIFO_DEPTH);
	assign accept        = s_axis_tvalid && s_axis_tready;

	cdpc_position u_position (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sof    (s_axis_tuser),
		.cfg    (cfg_q),
		.pos    (pos)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		cdpc_lane u_lane (
			.clk    (clk),
			.second (1'(i)),
			.fmt    (cfg_q.pixel_format),
			.word   (s_axis_tdata),
			.rgb    (lane_rgb[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept && (pos.kept != '0);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos;
		pos_s2 <= pos_s1;
		pos_s3 <= pos_s2;
	end

	always_comb begin
		entry.kept = pos_s3.kept;
		for (int i = 0; i < NUM_LANES; i++) begin
			entry.res[i].red   = lane_rgb[i].red;
			entry.res[i].green = lane_rgb[i].green;
			entry.res[i].blue  = lane_rgb[i].blue;
			entry.res[i].out_x = pos_s3.x[i];
			entry.res[i].out_y = pos_s3.y[i];
		end
	end

	cdpc_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (vld_s3),
		.entry         (entry),
		.count         (fifo_cnt),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- hw/rtl/cdpc_position.sv -----
// ----------------------------------------------------------------------------
// cdpc_position
// Source and destination position tracking; decides which pixels are kept.
// ----------------------------------------------------------------------------
module cdpc_position (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          sof,
	input  cdpc_pkg::cfg_t cfg,
	output cdpc_pkg::pos_t pos
);
	import cdpc_pkg::*;

	typedef struct packed {
		logic [DIM_W-1:0]   src_col;
		logic [DIM_W-1:0]   src_row;
		logic [STEP_W-1:0]  col_phase;
		logic [STEP_W-1:0]  row_phase;
		logic [COORD_W-1:0] dest_col;
		logic [COORD_W-1:0] dest_row;
	} cnt_t;

	typedef struct packed {
		logic [STEP_W-1:0] h;
		logic [STEP_W-1:0] v;
		logic [LIM_W-1:0]  start_x;
		logic [LIM_W-1:0]  start_y;
		logic [LIM_W-1:0]  wid;
		logic [LIM_W-1:0]  col_limit;
		logic [LIM_W-1:0]  row_limit;
	} lim_t;

	typedef struct packed {
		cnt_t               nxt;
		logic               kept;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} step_t;

	function automatic logic [STEP_W-1:0] next_phase(logic [STEP_W-1:0] ph,
			logic [STEP_W-1:0] st);
		logic [STEP_W:0] inc;
		inc = (STEP_W+1)'(ph) + 1'b1;
		return (inc >= (STEP_W+1)'(st)) ? '0 : inc[STEP_W-1:0];
	endfunction

	function automatic step_t take(cnt_t s, lim_t l);
		step_t             r;
		logic              col_go;
		logic              row_go;
		logic              col_ok;
		logic              row_ok;
		logic [CMP_W-1:0]  col_inc;
		logic [CMP_W-1:0]  row_inc;
		col_go  = CMP_W'(s.src_col) >= CMP_W'(l.start_x);
		row_go  = CMP_W'(s.src_row) >= CMP_W'(l.start_y);
		col_ok  = col_go && (CMP_W'(s.src_col) < CMP_W'(l.col_limit)) && (s.col_phase == '0);
		row_ok  = row_go && (CMP_W'(s.src_row) < CMP_W'(l.row_limit)) && (s.row_phase == '0);
		col_inc = CMP_W'(s.src_col) + 1'b1;
		row_inc = CMP_W'(s.src_row) + 1'b1;
		r.kept  = col_ok && row_ok;
		r.x     = s.dest_col;
		r.y     = s.dest_row;
		r.nxt   = s;
		if (r.kept) begin
			r.nxt.dest_col = s.dest_col + 1'b1;
		end
		if (col_go) begin
			r.nxt.col_phase = next_phase(s.col_phase, l.h);
		end
		// end of line
		if (col_inc >= CMP_W'(l.wid) || col_inc >= CMP_W'(MAX_DIM)) begin
			r.nxt.src_col   = '0;
			r.nxt.col_phase = '0;
			r.nxt.dest_col  = '0;
			if (row_ok) begin
				r.nxt.dest_row = s.dest_row + 1'b1;
			end
			if (row_go) begin
				r.nxt.row_phase = next_phase(s.row_phase, l.v);
			end
			r.nxt.src_row = (row_inc >= CMP_W'(MAX_DIM)) ? '0 : row_inc[DIM_W-1:0];
		end else begin
			r.nxt.src_col = col_inc[DIM_W-1:0];
		end
		return r;
	endfunction

	cnt_t  cnt_q;
	cnt_t  base;
	cnt_t  cnt_nxt;
	lim_t  lim;
	step_t st0;
	step_t st1;
	logic  two_pix;
	logic  one_pix;

	always_comb begin
		lim.h         = (cfg.h_step == '0) ? STEP_W'(1) : cfg.h_step;
		lim.v         = (cfg.v_step == '0) ? STEP_W'(1) : cfg.v_step;
		lim.start_x   = LIM_W'(cfg.crop_left) + LIM_W'(lim.h >> 1);
		lim.start_y   = LIM_W'(cfg.crop_top) + LIM_W'(lim.v >> 1);
		lim.wid       = (cfg.line_width == '0) ? LIM_W'(1) : cfg.line_width;
		lim.col_limit = cfg.col_limit;
		lim.row_limit = cfg.row_limit;
	end

	always_comb begin
		two_pix = (cfg.pixel_format == FMT_UYVY) || (cfg.pixel_format == FMT_YUYV)
			|| (cfg.pixel_format == FMT_BGR16);
		one_pix = (cfg.pixel_format == FMT_BGR24) || (cfg.pixel_format == FMT_RGB32)
			|| (cfg.pixel_format == FMT_BGR32);
		base    = sof ? '0 : cnt_q;
		// second pixel of a word continues from where the first left off
		st0     = take(base, lim);
		st1     = take(st0.nxt, lim);
		if (two_pix) begin
			cnt_nxt = st1.nxt;
		end else if (one_pix) begin
			cnt_nxt = st0.nxt;
		end else begin
			cnt_nxt = base;
		end
		pos.kept[0] = st0.kept && (two_pix || one_pix);
		pos.kept[1] = st1.kept && two_pix;
		pos.x[0]    = st0.x;
		pos.x[1]    = st1.x;
		pos.y[0]    = st0.y;
		pos.y[1]    = st1.y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_nxt;
		end
	end

endmodule

// ----- hw/rtl/cdpc_lane.sv -----
// ----------------------------------------------------------------------------
// cdpc_lane
// One pixel lane: picks its bytes from the word and converts to RGB888.
// ----------------------------------------------------------------------------
module cdpc_lane (
	input  logic                         clk,
	input  logic                         second,
	input  logic [cdpc_pkg::FMT_W-1:0]   fmt,
	input  logic [cdpc_pkg::WORD_W-1:0]  word,
	output cdpc_pkg::rgb_t               rgb
);
	import cdpc_pkg::*;

	function automatic logic [COLOUR_W-1:0] clamp8(logic signed [PROD_W-1:0] sum);
		logic signed [PROD_W-1:0] sh;
		sh = sum >>> 8;
		if (sh < 0) begin
			return '0;
		end else if (sh > PROD_W'(255)) begin
			return 8'hFF;
		end else begin
			return sh[COLOUR_W-1:0];
		end
	endfunction

	logic [COLOUR_W-1:0] b0, b1, b2, b3;
	logic [COLOUR_W-1:0] y_sel, u_sel, v_sel, lo, hi;
	logic                is_yuv;
	rgb_t                direct;

	logic signed [8:0]        c_s1, d_s1, e_s1;
	logic                     is_yuv_s1;
	rgb_t                     direct_s1;

	logic signed [PROD_W-1:0] yc_s2, re_s2, gd_s2, ge_s2, bd_s2;
	logic                     is_yuv_s2;
	rgb_t                     direct_s2;

	logic signed [PROD_W-1:0] sum_r, sum_g, sum_b;
	rgb_t                     conv;

	assign b0 = word[7:0];
	assign b1 = word[15:8];
	assign b2 = word[23:16];
	assign b3 = word[31:24];
	assign lo = second ? b2 : b0;
	assign hi = second ? b3 : b1;

	always_comb begin
		is_yuv = 1'b0;
		y_sel  = b1;
		u_sel  = b0;
		v_sel  = b2;
		direct = '0;
		case (fmt)
			FMT_UYVY: begin
				is_yuv = 1'b1;
				y_sel  = second ? b3 : b1;
				u_sel  = b0;
				v_sel  = b2;
			end
			FMT_YUYV: begin
				is_yuv = 1'b1;
				y_sel  = second ? b2 : b0;
				u_sel  = b1;
				v_sel  = b3;
			end
			FMT_BGR16: begin
				direct.blue  = {lo[4:0], 3'b000};
				direct.green = {hi[2:0], lo[7:5], 2'b00};
				direct.red   = {hi[7:3], 3'b000};
			end
			FMT_RGB32: begin
				direct.red   = b0;
				direct.green = b1;
				direct.blue  = b2;
			end
			default: begin
				direct.blue  = b0;
				direct.green = b1;
				direct.red   = b2;
			end
		endcase
	end

	// stage 1: offsets, stage 2: products, stage 3: sums and clamp
	always_ff @(posedge clk) begin
		c_s1      <= $signed({1'b0, y_sel}) - 9'sd16;
		d_s1      <= $signed({1'b0, u_sel}) - 9'sd128;
		e_s1      <= $signed({1'b0, v_sel}) - 9'sd128;
		is_yuv_s1 <= is_yuv;
		direct_s1 <= direct;

		yc_s2     <= PROD_W'(c_s1) * $signed(PROD_W'(298));
		re_s2     <= PROD_W'(e_s1) * $signed(PROD_W'(409));
		gd_s2     <= PROD_W'(d_s1) * $signed(PROD_W'(100));
		ge_s2     <= PROD_W'(e_s1) * $signed(PROD_W'(208));
		bd_s2     <= PROD_W'(d_s1) * $signed(PROD_W'(516));
		is_yuv_s2 <= is_yuv_s1;
		direct_s2 <= direct_s1;

		rgb       <= is_yuv_s2 ? conv : direct_s2;
	end

	always_comb begin
		sum_r      = yc_s2 + re_s2 + $signed(PROD_W'(128));
		sum_g      = yc_s2 - gd_s2 - ge_s2 + $signed(PROD_W'(128));
		sum_b      = yc_s2 + bd_s2 + $signed(PROD_W'(128));
		conv.red   = clamp8(sum_r);
		conv.green = clamp8(sum_g);
		conv.blue  = clamp8(sum_b);
	end

endmodule

// ----- hw/rtl/cdpc_merge.sv -----
// ----------------------------------------------------------------------------
// cdpc_merge
// Queue of per-word lane results, sent out one pixel per transaction.
// ----------------------------------------------------------------------------
module cdpc_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  cdpc_pkg::pair_t                   entry,
	output logic [cdpc_pkg::FIFO_CNT_W-1:0]   count,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [$bits(cdpc_pkg::res_t)-1:0] m_axis_tdata,
	output logic                              m_axis_tlast
);
	import cdpc_pkg::*;

	pair_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  sel_q;
	pair_t                 head;
	logic                  cur;
	logic                  pop;
	logic                  xfer;

	assign head          = mem_q[rd_ptr_q];
	// skip lane 0 when it kept nothing
	assign cur           = sel_q || !head.kept[0];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = head.res[cur];
	assign m_axis_tlast  = cur || !head.kept[1];
	assign xfer          = m_axis_tvalid && m_axis_tready;
	assign pop           = xfer && m_axis_tlast;
	assign count         = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sel_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				sel_q    <= 1'b0;
			end else if (xfer) begin
				sel_q <= 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the crop, decimate and pixel converter.
// ----------------------------------------------------------------------------
// Source words go out from a queue through a clocked driver with random gaps.
// The output side stalls at random. Every accepted word runs through a local
// model of the position counters and colour conversion. Each output
// transaction is compared with the oldest predicted pixel. Register settings
// change only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module testbench;
	import cdpc_pkg::*;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_WORDS = 1050;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              sof;
	} src_item_t;

	typedef struct {
		res_t pix;
		logic last;
	} kept_pixel_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [WORD_W-1:0]       s_axis_tdata = '0;  // source_word
	logic                    s_axis_tuser = 1'b0;  // start_of_frame
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [$bits(res_t)-1:0] m_axis_tdata;  // red, green, blue, out_x, out_y
	logic                    m_axis_tlast;  // last_of_run

	// local copy of the block's registers and counters
	cfg_t                conv_cfg;
	logic [COORD_W-1:0]  src_col, src_row, dest_col, dest_row;
	logic [STEP_W-1:0]   col_phase, row_phase;

	src_item_t   word_queue[$];
	kept_pixel_t pixel_queue[$];

	int cycles = 0;
	int mismatches = 0;
	int words_sent = 0;
	int words_taken = 0;
	int pixels_checked = 0;
	int settings_applied = 0;
	int in_gap = 0;
	int out_stall = 0;
	int calm_left = 0;

	crop_decimate_pixel_converter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// mostly short gaps, a few long ones, now and then a calm stretch
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 62)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_position();
		src_col   = '0;
		src_row   = '0;
		col_phase = '0;
		row_phase = '0;
		dest_col  = '0;
		dest_row  = '0;
	endfunction

	function automatic logic [COLOUR_W-1:0] clamp_byte(int val);
		if (val < 0)
			return 8'd0;
		if (val > 255)
			return 8'd255;
		return val[7:0];
	endfunction

	// integer bt.601, the arithmetic shift gives a floor division
	function automatic rgb_t yuv_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
		int   c, d, e;
		rgb_t px;
		c = int'(y) - 16;
		d = int'(u) - 128;
		e = int'(v) - 128;
		px.red   = clamp_byte((298 * c + 409 * e + 128) >>> 8);
		px.green = clamp_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
		px.blue  = clamp_byte((298 * c + 516 * d + 128) >>> 8);
		return px;
	endfunction

	// works out the kept pixels of one source word and queues them
	function automatic void convert_word(logic [WORD_W-1:0] word, logic sof);
		logic [7:0]  b0, b1, b2, b3, lo, hi;
		int          npix, h, v, start_x, start_y, wid, n, p;
		bit          col_ok, row_ok;
		rgb_t        px;
		res_t        run_pix[2];
		kept_pixel_t kp;
		{b3, b2, b1, b0} = word;
		if (sof)
			clear_position();
		if (conv_cfg.pixel_format <= FMT_BGR16)
			npix = 2;
		else if (conv_cfg.pixel_format <= FMT_BGR32)
			npix = 1;
		else
			npix = 0;
		h = (conv_cfg.h_step == 0) ? 1 : int'(conv_cfg.h_step);
		v = (conv_cfg.v_step == 0) ? 1 : int'(conv_cfg.v_step);
		start_x = int'(conv_cfg.crop_left) + h / 2;
		start_y = int'(conv_cfg.crop_top) + v / 2;
		wid = (conv_cfg.line_width == 0) ? 1 : int'(conv_cfg.line_width);
		n = 0;
		for (p = 0; p < npix; p++) begin
			case (conv_cfg.pixel_format)
				FMT_UYVY: px = yuv_pixel(p ? b3 : b1, b0, b2);
				FMT_YUYV: px = yuv_pixel(p ? b2 : b0, b1, b3);
				FMT_BGR16: begin
					lo = p ? b2 : b0;
					hi = p ? b3 : b1;
					px.blue  = {lo[4:0], 3'b000};
					px.green = {hi[2:0], lo[7:5], 2'b00};
					px.red   = {hi[7:3], 3'b000};
				end
				FMT_RGB32: begin
					px.red   = b0;
					px.green = b1;
					px.blue  = b2;
				end
				default: begin
					px.red   = b2;
					px.green = b1;
					px.blue  = b0;
				end
			endcase
			col_ok = int'(src_col) >= start_x && int'(src_col) < int'(conv_cfg.col_limit)
				&& col_phase == 0;
			row_ok = int'(src_row) >= start_y && int'(src_row) < int'(conv_cfg.row_limit)
				&& row_phase == 0;
			if (col_ok && row_ok) begin
				run_pix[n].red   = px.red;
				run_pix[n].green = px.green;
				run_pix[n].blue  = px.blue;
				run_pix[n].out_x = dest_col;
				run_pix[n].out_y = dest_row;
				n++;
				dest_col = dest_col + 1'b1;
			end
			if (int'(src_col) >= start_x)
				col_phase = (int'(col_phase) + 1 >= h) ? '0 : col_phase + 1'b1;
			// end of line, either the programmed width or the counter range
			if (int'(src_col) + 1 >= wid || int'(src_col) + 1 >= MAX_DIM) begin
				src_col   = '0;
				col_phase = '0;
				dest_col  = '0;
				if (row_ok)
					dest_row = dest_row + 1'b1;
				if (int'(src_row) >= start_y)
					row_phase = (int'(row_phase) + 1 >= v) ? '0 : row_phase + 1'b1;
				src_row = (int'(src_row) + 1 >= MAX_DIM) ? '0 : src_row + 1'b1;
			end else begin
				src_col = src_col + 1'b1;
			end
		end
		for (p = 0; p < n; p++) begin
			kp.pix  = run_pix[p];
			kp.last = (p == n - 1);
			pixel_queue.push_back(kp);
		end
	endfunction

	function automatic void check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// input side: accepted words and register writes feed the model
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$error("no progress after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end else if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				convert_word(s_axis_tdata, s_axis_tuser);
				words_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PIXEL_FORMAT: conv_cfg.pixel_format = cfg_data[FMT_W-1:0];
					REG_LINE_WIDTH:   conv_cfg.line_width   = cfg_data[LIM_W-1:0];
					REG_CROP_LEFT:    conv_cfg.crop_left    = cfg_data[CROP_W-1:0];
					REG_COL_LIMIT:    conv_cfg.col_limit    = cfg_data[LIM_W-1:0];
					REG_CROP_TOP:     conv_cfg.crop_top     = cfg_data[CROP_W-1:0];
					REG_ROW_LIMIT:    conv_cfg.row_limit    = cfg_data[LIM_W-1:0];
					REG_H_STEP:       conv_cfg.h_step       = cfg_data[STEP_W-1:0];
					REG_V_STEP:       conv_cfg.v_step       = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// output side: compare each transaction with the oldest prediction
	always @(posedge clk) begin
		kept_pixel_t want;
		res_t        got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pixel_queue.size() == 0) begin
				$error("unexpected pixel at x %0d y %0d", got.out_x, got.out_y);
				mismatches++;
			end else begin
				want = pixel_queue.pop_front();
				check_field("red", int'(want.pix.red), int'(got.red));
				check_field("green", int'(want.pix.green), int'(got.green));
				check_field("blue", int'(want.pix.blue), int'(got.blue));
				check_field("out_x", int'(want.pix.out_x), int'(got.out_x));
				check_field("out_y", int'(want.pix.out_y), int'(got.out_y));
				check_field("last_of_run", int'(want.last), int'(m_axis_tlast));
				pixels_checked++;
			end
		end
	end

	// driver: a word stays on the bus until its transaction completes
	always @(negedge clk) begin
		src_item_t item;
		if (arst_n) begin
			if (!s_axis_tvalid || words_taken == words_sent) begin
				if (in_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					in_gap--;
				end else if (word_queue.size() != 0) begin
					item = word_queue.pop_front();
					s_axis_tdata  <= item.word;
					s_axis_tuser  <= item.sof;
					s_axis_tvalid <= 1'b1;
					words_sent++;
					in_gap = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (out_stall > 0) begin
				m_axis_tready <= 1'b0;
				out_stall--;
			end else begin
				m_axis_tready <= 1'b1;
				out_stall = pick_gap();
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(int fmt, int lw, int cl, int cm, int ct, int rl, int hs, int vs);
		write_reg(REG_PIXEL_FORMAT, fmt);
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_CROP_LEFT, cl);
		write_reg(REG_COL_LIMIT, cm);
		write_reg(REG_CROP_TOP, ct);
		write_reg(REG_ROW_LIMIT, rl);
		write_reg(REG_H_STEP, hs);
		write_reg(REG_V_STEP, vs);
		settings_applied++;
	endtask

	function automatic void add_word(logic [WORD_W-1:0] word, logic sof);
		src_item_t item;
		item.word = word;
		item.sof  = sof;
		word_queue.push_back(item);
	endfunction

	// the block may still be busy on words that leave nothing behind
	task automatic wait_for_drain();
		while (word_queue.size() != 0 || s_axis_tvalid || pixel_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int phase, n_words, frame_len, pos, r, random_words;
		int fmt, lw, cl, cm, ct, rl, hs, vs;
		int lim_extremes[4];
		lim_extremes = '{0, 4095, 4096, 8191};
		conv_cfg.pixel_format = FMT_UYVY;
		conv_cfg.line_width   = LIM_W'(640);
		conv_cfg.crop_left    = '0;
		conv_cfg.col_limit    = LIM_W'(640);
		conv_cfg.crop_top     = '0;
		conv_cfg.row_limit    = LIM_W'(480);
		conv_cfg.h_step       = STEP_W'(1);
		conv_cfg.v_step       = STEP_W'(1);
		clear_position();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register values straight out of reset
		add_word(32'h10EB_80F0, 1'b1);
		add_word(32'hFFFF_FFFF, 1'b0);
		wait_for_drain();

		// every format, including both invalid codes, on an odd line width
		for (fmt = 0; fmt < 8; fmt++) begin
			apply_settings(fmt, 3, 0, 4096, 0, 4096, 1, 1);
			add_word(32'hFFFF_FFFF, 1'b1);
			add_word(32'h0000_0000, 1'b0);
			add_word(32'h10EB_80F0, 1'b0);
			wait_for_drain();
		end

		random_words = 0;
		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			r = $urandom_range(0, 15);
			fmt = (r < 14) ? r % 6 : r - 8;
			lw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 24);
			cl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, lw / 3);
			cm = ($urandom_range(0, 9) == 0) ? lim_extremes[$urandom_range(0, 3)]
				: $urandom_range(0, lw + 2);
			ct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 3);
			rl = ($urandom_range(0, 9) == 0) ? lim_extremes[$urandom_range(0, 3)]
				: $urandom_range(0, 30);
			hs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
			vs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
			n_words = $urandom_range(50, 110);
			case (phase)
				0: begin
					// zero width and zero steps behave as one
					lw = 0;
					hs = 0;
					vs = 0;
					rl = 30;
				end
				1: begin
					// very long programmed line with a wide column step
					fmt = FMT_BGR16;
					lw = 8191;
					cl = 0;
					cm = 8191;
					ct = 0;
					rl = 2;
					hs = 32;
					vs = 1;
				end
				2: begin
					// crop start at the end of the counter range keeps nothing
					cl = 4095;
					ct = 4095;
					cm = 4096;
					rl = 4096;
				end
				3: begin
					fmt = FMT_YUYV;
					lw = 7;
				end
				4: begin
					// one pixel per line with a tall row step
					fmt = FMT_BGR16;
					lw = 1;
					cl = 0;
					cm = 1;
					ct = $urandom_range(0, 40);
					rl = 4096;
					hs = 1;
					vs = 64;
				end
				default: ;
			endcase
			apply_settings(fmt, lw, cl, cm, ct, rl, hs, vs);
			// frames with random content, some stray frame starts and a few phases
			// that pick up in the middle of a frame
			frame_len = $urandom_range(8, 160);
			pos = ($urandom_range(0, 4) == 0) ? 1 : 0;
			repeat (n_words) begin
				add_word($urandom(), pos == 0 || $urandom_range(0, 49) == 0);
				pos = (pos + 1 >= frame_len) ? 0 : pos + 1;
			end
			random_words += n_words;
			wait_for_drain();
			phase++;
		end

		wait_for_drain();
		$display("%0d source words accepted, %0d output pixels compared", words_taken,
			pixels_checked);
		$display("%0d register settings: all formats, crop, limit and step extremes",
			settings_applied);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
